// ----- sv/keyboard_matrix_with_key_queue_defines.svh -----
// Assertion helpers for the keyboard matrix block.
// Both expect clk and rst_n in the enclosing scope.
`ifndef KEYBOARD_MATRIX_WITH_KEY_QUEUE_DEFINES_SVH
`define KEYBOARD_MATRIX_WITH_KEY_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define KMKQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KMKQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/kmkq_pkg.sv -----
package kmkq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_CODES_DEF   = 256;

    localparam int CYCLE_W    = 48;
    localparam int THR_W      = 24;
    localparam int KEY_W      = 8;
    localparam int ACT_W      = 2;
    localparam int POS_W      = 3;
    localparam int FORCE_W    = 2;
    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 8;
    localparam int DATA_W     = 8;
    localparam int ROWS       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EVENT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SHIFT = 2'd2;

    localparam logic [THR_W-1:0] THROTTLE_RST    = 24'd50000;
    localparam logic [KEY_W-1:0] LEFT_SHIFT_RST  = 8'd254;
    localparam logic [KEY_W-1:0] RIGHT_SHIFT_RST = 8'd255;

    localparam logic [FORCE_W-1:0] FORCE_NONE = 2'd0;
    localparam logic [FORCE_W-1:0] FORCE_DOWN = 2'd1;
    localparam logic [FORCE_W-1:0] FORCE_UP   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BASE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IGNORE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALT    = 2'd2;

    localparam int                SHIFT_ROW       = 7;
    localparam logic [DATA_W-1:0] SHIFT_DOWN_MASK = 8'h01;
    localparam logic [DATA_W-1:0] SHIFT_UP_MASK   = 8'h03;

    localparam logic [CYCLE_W-1:0] CYCLE_MAX = {CYCLE_W{1'b1}};

    typedef struct packed {
        logic               valid;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [FORCE_W-1:0] force_code;
        logic [MODE_W-1:0]  smode;
        logic [POS_W-1:0]   srow;
        logic [POS_W-1:0]   scol;
        logic [FORCE_W-1:0] sforce;
        logic               sap;
    } map_entry_t;

    typedef struct packed {
        logic             press;
        logic [KEY_W-1:0] key;
    } key_event_t;

    typedef struct packed {
        logic idle;
        logic clear_step;
        logic exec;
        logic event_step;
        logic apply_step;
        logic result_load;
    } kmkq_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic clear_done;
        logic dequeue;
        logic out_free;
    } kmkq_sts_t;

endpackage

// ----- sv/kmkq_item_if.sv -----
interface kmkq_item_if import kmkq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [KEY_W-1:0]   key_code;
    logic               is_press;
    logic [POS_W-1:0]   map_row;
    logic [POS_W-1:0]   map_column;
    logic [FORCE_W-1:0] map_force;
    logic [MODE_W-1:0]  shifted_mode;
    logic [POS_W-1:0]   shifted_row;
    logic [POS_W-1:0]   shifted_column;
    logic [FORCE_W-1:0] shifted_force;
    logic [ADDR_W-1:0]  read_address;
    logic [CYCLE_W-1:0] now_cycle;

    modport source (
        output valid, action, key_code, is_press, map_row, map_column, map_force,
               shifted_mode, shifted_row, shifted_column, shifted_force,
               read_address, now_cycle,
        input  ready
    );

    modport sink (
        input  valid, action, key_code, is_press, map_row, map_column, map_force,
               shifted_mode, shifted_row, shifted_column, shifted_force,
               read_address, now_cycle,
        output ready
    );
endinterface

// ----- sv/kmkq_result_if.sv -----
interface kmkq_result_if import kmkq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              event_applied;
    logic              queue_dropped;

    modport source (
        output valid, read_data, event_applied, queue_dropped,
        input  ready
    );

    modport sink (
        input  valid, read_data, event_applied, queue_dropped,
        output ready
    );
endinterface

// ----- sv/kmkq_ram.sv -----
module kmkq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- sv/kmkq_datapath.sv -----
module kmkq_datapath import kmkq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int KEY_CODES   = KEY_CODES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    kmkq_item_if.sink             item,
    kmkq_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  kmkq_cmd_t             cmd,
    output kmkq_sts_t             sts
);
    localparam int QA_W  = $clog2(QUEUE_DEPTH);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int KA_W  = $clog2(KEY_CODES);
    localparam int MAP_W = $bits(map_entry_t);
    localparam int EV_W  = $bits(key_event_t);

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic [KEY_W-1:0] lcode_reg;
    logic [KEY_W-1:0] rcode_reg;

    // latched transaction
    logic [ACT_W-1:0]   act_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               press_reg;
    logic [POS_W-1:0]   row_reg;
    logic [POS_W-1:0]   col_reg;
    logic [FORCE_W-1:0] force_in_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [POS_W-1:0]   srow_reg;
    logic [POS_W-1:0]   scol_reg;
    logic [FORCE_W-1:0] sforce_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CYCLE_W-1:0] now_reg;

    // matrix and queue state
    logic [DATA_W-1:0]  key_rows_reg [ROWS];
    logic [FORCE_W-1:0] force_reg;
    logic               lheld_reg;
    logic               rheld_reg;
    logic [CYCLE_W-1:0] mark_reg;
    logic [QA_W-1:0]    head_reg;
    logic [QC_W-1:0]    count_reg;
    logic               applied_reg;
    logic               dropped_reg;
    logic [KEY_W-1:0]   ev_key_reg;
    logic               ev_press_reg;
    logic               ev_ok_reg;
    logic [KA_W-1:0]    clr_addr_reg;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic               out_applied_reg;
    logic               out_dropped_reg;

    logic               take;
    logic               key_ok;
    logic               queue_full;
    logic [QA_W:0]      tail_sum;
    logic [QA_W-1:0]    tail;
    logic [QA_W-1:0]    head_next;
    logic               dequeue;
    logic [CYCLE_W:0]   mark_sum;
    logic [CYCLE_W-1:0] mark_next;

    logic               q_we;
    logic [EV_W-1:0]    q_wdata;
    logic [EV_W-1:0]    q_rdata;
    key_event_t         ev;

    logic               m_we;
    logic [KA_W-1:0]    m_waddr;
    logic [MAP_W-1:0]   m_wdata;
    logic [KA_W-1:0]    m_raddr;
    logic [MAP_W-1:0]   m_rdata;
    map_entry_t         me;
    map_entry_t         load_entry;
    map_entry_t         press_entry;

    logic               apply_hit;
    logic               shifted;
    logic               use_alt;
    logic               ignore_key;
    logic [POS_W-1:0]   sel_row;
    logic [POS_W-1:0]   sel_col;
    logic [FORCE_W-1:0] sel_force;
    logic [DATA_W-1:0]  rd_or;

    assign take       = cmd.idle && item.valid;
    assign item.ready = cmd.idle;

    assign key_ok     = int'(key_reg) < KEY_CODES;
    assign queue_full = count_reg == QC_W'(QUEUE_DEPTH);
    assign tail_sum   = (QA_W+1)'(head_reg) + (QA_W+1)'(count_reg);
    assign tail       = (tail_sum >= (QA_W+1)'(QUEUE_DEPTH)) ?
                        QA_W'(tail_sum - (QA_W+1)'(QUEUE_DEPTH)) : QA_W'(tail_sum);
    assign head_next  = (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign dequeue    = (act_reg == ACT_READ) && (now_reg > mark_reg) && (count_reg != '0);
    assign mark_sum   = {1'b0, now_reg} + (CYCLE_W+1)'(thr_reg);
    assign mark_next  = mark_sum[CYCLE_W] ? CYCLE_MAX : mark_sum[CYCLE_W-1:0];

    assign sts.in_valid   = item.valid;
    assign sts.clear_done = clr_addr_reg == KA_W'(KEY_CODES - 1);
    assign sts.dequeue    = dequeue;
    assign sts.out_free   = !out_valid_reg || result.ready;

    // event queue
    assign q_we    = cmd.exec && (act_reg == ACT_EVENT) && !queue_full;
    assign q_wdata = {press_reg, key_reg};
    assign ev      = key_event_t'(q_rdata);

    kmkq_ram #(
        .WIDTH (EV_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail),
        .wdata (q_wdata),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    // key map
    assign m_raddr = KA_W'(ev.key);
    assign me      = map_entry_t'(m_rdata);

    always_comb
    begin
        load_entry            = '0;
        load_entry.valid      = 1'b1;
        load_entry.row        = row_reg;
        load_entry.col        = col_reg;
        load_entry.force_code = force_in_reg;
        load_entry.smode      = (mode_reg == MODE_IGNORE || mode_reg == MODE_ALT) ?
                                mode_reg : MODE_BASE;
        load_entry.srow       = srow_reg;
        load_entry.scol       = scol_reg;
        load_entry.sforce     = sforce_reg;
        load_entry.sap        = 1'b0;
    end

    assign apply_hit  = ev_ok_reg && me.valid;
    assign shifted    = ev_press_reg ? (lheld_reg || rheld_reg) : me.sap;
    assign use_alt    = shifted && (me.smode == MODE_IGNORE || me.smode == MODE_ALT);
    assign ignore_key = use_alt && (me.smode == MODE_IGNORE);
    assign sel_row    = use_alt ? me.srow : me.row;
    assign sel_col    = use_alt ? me.scol : me.col;
    assign sel_force  = use_alt ? me.sforce : me.force_code;

    always_comb
    begin
        press_entry     = me;
        press_entry.sap = shifted;
    end

    always_comb
    begin
        m_we    = 1'b0;
        m_waddr = clr_addr_reg;
        m_wdata = '0;
        if (cmd.clear_step)
        begin
            m_we = 1'b1;
        end
        else if (cmd.exec && (act_reg == ACT_LOAD) && key_ok)
        begin
            m_we    = 1'b1;
            m_waddr = KA_W'(key_reg);
            m_wdata = load_entry;
        end
        else if (cmd.apply_step && apply_hit && ev_press_reg)
        begin
            m_we    = 1'b1;
            m_waddr = KA_W'(ev_key_reg);
            m_wdata = press_entry;
        end
    end

    kmkq_ram #(
        .WIDTH (MAP_W),
        .DEPTH (KEY_CODES)
    ) u_map_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // read view of the matrix
    always_comb
    begin
        logic [DATA_W-1:0] b;
        rd_or = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            b = key_rows_reg[i];
            if (i == SHIFT_ROW)
            begin
                if (force_reg == FORCE_DOWN)
                begin
                    b = b | SHIFT_DOWN_MASK;
                end
                else if (force_reg == FORCE_UP)
                begin
                    b = b & ~SHIFT_UP_MASK;
                end
            end
            if (addr_reg[i])
            begin
                rd_or = rd_or | b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THROTTLE_RST;
            lcode_reg <= LEFT_SHIFT_RST;
            rcode_reg <= RIGHT_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THROTTLE:    thr_reg   <= cfg_data;
                CFG_LEFT_SHIFT:  lcode_reg <= cfg_data[KEY_W-1:0];
                CFG_RIGHT_SHIFT: rcode_reg <= cfg_data[KEY_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            act_reg      <= item.action;
            key_reg      <= item.key_code;
            press_reg    <= item.is_press;
            row_reg      <= item.map_row;
            col_reg      <= item.map_column;
            force_in_reg <= item.map_force;
            mode_reg     <= item.shifted_mode;
            srow_reg     <= item.shifted_row;
            scol_reg     <= item.shifted_column;
            sforce_reg   <= item.shifted_force;
            addr_reg     <= item.read_address;
            now_reg      <= item.now_cycle;
        end
        if (cmd.event_step)
        begin
            ev_key_reg   <= ev.key;
            ev_press_reg <= ev.press;
            ev_ok_reg    <= int'(ev.key) < KEY_CODES;
        end
        if (cmd.result_load)
        begin
            out_data_reg    <= (act_reg == ACT_READ) ? rd_or : '0;
            out_applied_reg <= applied_reg;
            out_dropped_reg <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                key_rows_reg[i] <= '0;
            end
            force_reg     <= FORCE_NONE;
            lheld_reg     <= 1'b0;
            rheld_reg     <= 1'b0;
            mark_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            applied_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step && !sts.clear_done)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (take)
            begin
                applied_reg <= 1'b0;
                dropped_reg <= 1'b0;
            end
            if (cmd.exec)
            begin
                if (act_reg == ACT_EVENT)
                begin
                    if (queue_full)
                    begin
                        dropped_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                else if (dequeue)
                begin
                    head_reg    <= head_next;
                    count_reg   <= count_reg - 1'b1;
                    mark_reg    <= mark_next;
                    applied_reg <= 1'b1;
                end
            end
            if (cmd.event_step)
            begin
                if (ev.key == lcode_reg)
                begin
                    lheld_reg <= ev.press;
                end
                if (ev.key == rcode_reg)
                begin
                    rheld_reg <= ev.press;
                end
            end
            if (cmd.apply_step && apply_hit && !ignore_key)
            begin
                force_reg <= sel_force;
                key_rows_reg[sel_row][sel_col] <= ev_press_reg;
            end
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.read_data     = out_data_reg;
    assign result.event_applied = out_applied_reg;
    assign result.queue_dropped = out_dropped_reg;
endmodule

// ----- sv/kmkq_ctrl.sv -----
`include "keyboard_matrix_with_key_queue_defines.svh"

module kmkq_ctrl import kmkq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  kmkq_sts_t sts,
    output kmkq_cmd_t cmd
);
    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_EVENT  = 6'b001000,
        S_APPLY  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (sts.clear_done) state_next = S_IDLE;
            S_IDLE:   if (sts.in_valid) state_next = S_EXEC;
            S_EXEC:   state_next = sts.dequeue ? S_EVENT : S_RESULT;
            S_EVENT:  state_next = S_APPLY;
            S_APPLY:  state_next = S_RESULT;
            S_RESULT: if (sts.out_free) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.clear_step  = state_reg == S_CLEAR;
    assign cmd.idle        = state_reg == S_IDLE;
    assign cmd.exec        = state_reg == S_EXEC;
    assign cmd.event_step  = state_reg == S_EVENT;
    assign cmd.apply_step  = state_reg == S_APPLY;
    assign cmd.result_load = (state_reg == S_RESULT) && sts.out_free;

    `KMKQ_ASSERT_NEXT(a_take_to_exec, state_reg == S_IDLE && sts.in_valid,
        state_reg == S_EXEC, "accepted transaction did not start execution")
    `KMKQ_ASSERT_NEXT(a_clear_to_idle, state_reg == S_CLEAR && sts.clear_done,
        state_reg == S_IDLE, "map clear did not finish")
    `KMKQ_ASSERT_NOW(a_apply_after_event, state_reg == S_APPLY,
        $past(state_reg) == S_EVENT, "map apply without queue read")
    `KMKQ_ASSERT_NOW(a_result_free, cmd.result_load,
        sts.out_free, "result loaded over a pending transaction")
endmodule

// ----- sv/keyboard_matrix_with_key_queue.sv -----
// Keyboard matrix with a throttled key event queue.
// Channel item (sink) takes one transaction per action: map load, key event
// or keyboard read. Channel result (source) returns exactly one transaction
// per item: read_data, event_applied and queue_dropped.
// cfg_we/cfg_index/cfg_data write throttle_cycles and the two shift key codes;
// write only while no item is in flight.
// Flow: a load, an event, or a read that dequeues nothing passes the execute
// and result states before result.valid rises; a read that applies a queued
// event also passes the event and apply states, as the event is read from the
// queue RAM and then its map entry from the map RAM, each with a registered
// read. The next item is accepted once the result is in the output register.
// Reset: a clearing pass writes every map entry as invalid, one per cycle, and
// item.ready stays low until it is done. Configuration returns to its defaults.
// Stall: the result register holds until result.ready; one further item may
// be accepted meanwhile, and it waits to load its result until that is taken.
module keyboard_matrix_with_key_queue import kmkq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int KEY_CODES   = KEY_CODES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    kmkq_item_if.sink             item,
    kmkq_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    kmkq_cmd_t cmd;
    kmkq_sts_t sts;

    kmkq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    kmkq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_CODES   (KEY_CODES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule

// ----- sim/tb_keyboard_matrix_with_key_queue.sv -----
module tb_keyboard_matrix_with_key_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import kmkq_pkg::*;

    localparam logic [ACT_W-1:0]   ACT_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0]  MODE_SPARE  = 2'd3;
    localparam logic [FORCE_W-1:0] FORCE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int REPORT_MAX  = 10;
    localparam int HOT_KEYS    = 6;
    localparam int PHASE_ITEMS = 70;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [KEY_W-1:0]   key_code;
        logic               is_press;
        logic [POS_W-1:0]   map_row;
        logic [POS_W-1:0]   map_column;
        logic [FORCE_W-1:0] map_force;
        logic [MODE_W-1:0]  shifted_mode;
        logic [POS_W-1:0]   shifted_row;
        logic [POS_W-1:0]   shifted_column;
        logic [FORCE_W-1:0] shifted_force;
        logic [ADDR_W-1:0]  read_address;
        logic [CYCLE_W-1:0] now_cycle;
    } kb_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              event_applied;
        logic              queue_dropped;
    } kb_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kmkq_item_if   item_bus ();
    kmkq_result_if result_bus ();

    keyboard_matrix_with_key_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF),
        .KEY_CODES  (KEY_CODES_DEF)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_bus),
        .result   (result_bus),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predicted block state
    logic [THR_W-1:0]   throttle_setting;
    logic [KEY_W-1:0]   left_shift_key;
    logic [KEY_W-1:0]   right_shift_key;
    logic [DATA_W-1:0]  matrix_rows [ROWS];
    logic [FORCE_W-1:0] row7_force;
    logic               left_shift_down;
    logic               right_shift_down;
    logic [CYCLE_W-1:0] dequeue_mark;
    key_event_t         queued_key_events [$];
    map_entry_t         key_map [KEY_CODES_DEF];

    kb_result_t         responses_due [$];
    logic [KEY_W-1:0]   hot_keys [HOT_KEYS];

    int burst_left;
    int mismatch_count;
    int cycle_count;
    int rx_cycle;
    int rx_stall_left;
    int loads_sent;
    int events_sent;
    int reads_sent;
    int unused_sent;
    int events_applied;
    int events_dropped;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic dequeue_key_event();
        key_event_t       ev;
        map_entry_t       ent;
        logic             shifted;
        logic             use_alt;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        if (queued_key_events.size() == 0)
            return 1'b0;
        ev = queued_key_events[0];
        queued_key_events.delete(0);
        if (ev.key == left_shift_key)
            left_shift_down = ev.press;
        if (ev.key == right_shift_key)
            right_shift_down = ev.press;
        ent = key_map[ev.key];
        if (!ent.valid)
            return 1'b1;
        if (ev.press)
        begin
            shifted = left_shift_down || right_shift_down;
            key_map[ev.key].sap = shifted;
        end
        else
            shifted = ent.sap;
        use_alt = shifted && (ent.smode == MODE_IGNORE || ent.smode == MODE_ALT);
        if (use_alt && ent.smode == MODE_IGNORE)
            return 1'b1;
        row = use_alt ? ent.srow : ent.row;
        col = use_alt ? ent.scol : ent.col;
        row7_force = use_alt ? ent.sforce : ent.force_code;
        matrix_rows[row][col] = ev.press;
        return 1'b1;
    endfunction

    function automatic kb_result_t predict_transaction(input kb_item_t it);
        kb_result_t         res;
        map_entry_t         ent;
        key_event_t         ev;
        logic [DATA_W-1:0]  byte_val;
        logic [CYCLE_W-1:0] thr_wide;
        res = '0;
        case (it.action)
            ACT_LOAD:
            begin
                loads_sent++;
                ent.valid      = 1'b1;
                ent.row        = it.map_row;
                ent.col        = it.map_column;
                ent.force_code = it.map_force;
                ent.smode      = (it.shifted_mode == MODE_SPARE) ? MODE_BASE : it.shifted_mode;
                ent.srow       = it.shifted_row;
                ent.scol       = it.shifted_column;
                ent.sforce     = it.shifted_force;
                ent.sap        = 1'b0;
                key_map[it.key_code] = ent;
            end
            ACT_EVENT:
            begin
                events_sent++;
                if (queued_key_events.size() >= QUEUE_DEPTH_DEF)
                begin
                    res.queue_dropped = 1'b1;
                    events_dropped++;
                end
                else
                begin
                    ev.press = it.is_press;
                    ev.key   = it.key_code;
                    queued_key_events.push_back(ev);
                end
            end
            ACT_READ:
            begin
                reads_sent++;
                if (it.now_cycle > dequeue_mark)
                begin
                    if (dequeue_key_event())
                    begin
                        res.event_applied = 1'b1;
                        events_applied++;
                        thr_wide = {{(CYCLE_W-THR_W){1'b0}}, throttle_setting};
                        if (it.now_cycle > CYCLE_MAX - thr_wide)
                            dequeue_mark = CYCLE_MAX;
                        else
                            dequeue_mark = it.now_cycle + thr_wide;
                    end
                end
                for (int i = 0; i < ROWS; i++)
                begin
                    if (it.read_address[i])
                    begin
                        byte_val = matrix_rows[i];
                        if (i == SHIFT_ROW)
                        begin
                            if (row7_force == FORCE_DOWN)
                                byte_val = byte_val | SHIFT_DOWN_MASK;
                            else if (row7_force == FORCE_UP)
                                byte_val = byte_val & ~SHIFT_UP_MASK;
                        end
                        res.read_data = res.read_data | byte_val;
                    end
                end
            end
            default:
                unused_sent++;
        endcase
        return res;
    endfunction

    function automatic kb_item_t random_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(kb_item_t)-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [31:0] raw;
        raw = $urandom;
        if ($urandom_range(0, 3) != 0)
            return hot_keys[$urandom_range(0, HOT_KEYS-1)];
        return raw[KEY_W-1:0];
    endfunction

    function automatic logic [CYCLE_W-1:0] pick_read_cycle();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        // an empty queue leaves the mark alone, so any cycle count is harmless
        if (queued_key_events.size() == 0 && $urandom_range(0, 3) == 0)
            return raw[CYCLE_W-1:0];
        if ($urandom_range(0, 3) != 0)
            return dequeue_mark + 1 + $urandom_range(0, 3);
        return (dequeue_mark > 7) ? dequeue_mark - $urandom_range(0, 7) : dequeue_mark;
    endfunction

    function automatic void refresh_hot_keys();
        logic [31:0] raw;
        hot_keys[0] = left_shift_key;
        hot_keys[1] = right_shift_key;
        for (int i = 2; i < HOT_KEYS; i++)
        begin
            raw = $urandom;
            hot_keys[i] = raw[KEY_W-1:0];
        end
    endfunction

    function automatic void log_mismatch(input string what, input kb_result_t due,
                                         input kb_result_t seen);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t ns: %s: expected data %02h applied %0b dropped %0b, got %02h %0b %0b",
                     $time, what, due.read_data, due.event_applied, due.queue_dropped,
                     seen.read_data, seen.event_applied, seen.queue_dropped);
    endfunction

    task automatic send_item(input kb_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                item_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_bus.action         <= it.action;
        item_bus.key_code       <= it.key_code;
        item_bus.is_press       <= it.is_press;
        item_bus.map_row        <= it.map_row;
        item_bus.map_column     <= it.map_column;
        item_bus.map_force      <= it.map_force;
        item_bus.shifted_mode   <= it.shifted_mode;
        item_bus.shifted_row    <= it.shifted_row;
        item_bus.shifted_column <= it.shifted_column;
        item_bus.shifted_force  <= it.shifted_force;
        item_bus.read_address   <= it.read_address;
        item_bus.now_cycle      <= it.now_cycle;
        item_bus.valid          <= 1'b1;
        do
            @(posedge clk);
        while (!item_bus.ready);
        responses_due.push_back(predict_transaction(it));
    endtask

    task automatic send_load(input logic [KEY_W-1:0] key,
                             input logic [POS_W-1:0] row, input logic [POS_W-1:0] col,
                             input logic [FORCE_W-1:0] frc, input logic [MODE_W-1:0] mode,
                             input logic [POS_W-1:0] srow, input logic [POS_W-1:0] scol,
                             input logic [FORCE_W-1:0] sfrc);
        kb_item_t it;
        it = random_item();
        it.action         = ACT_LOAD;
        it.key_code       = key;
        it.map_row        = row;
        it.map_column     = col;
        it.map_force      = frc;
        it.shifted_mode   = mode;
        it.shifted_row    = srow;
        it.shifted_column = scol;
        it.shifted_force  = sfrc;
        send_item(it);
    endtask

    task automatic send_key_event(input logic [KEY_W-1:0] key, input logic press);
        kb_item_t it;
        it = random_item();
        it.action   = ACT_EVENT;
        it.key_code = key;
        it.is_press = press;
        send_item(it);
    endtask

    task automatic send_read(input logic [ADDR_W-1:0] addr, input logic [CYCLE_W-1:0] now);
        kb_item_t it;
        it = random_item();
        it.action       = ACT_READ;
        it.read_address = addr;
        it.now_cycle    = now;
        send_item(it);
    endtask

    task automatic wait_for_responses();
        item_bus.valid <= 1'b0;
        burst_left = 0;
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_THROTTLE:    throttle_setting = value[THR_W-1:0];
            CFG_LEFT_SHIFT:  left_shift_key   = value[KEY_W-1:0];
            CFG_RIGHT_SHIFT: right_shift_key  = value[KEY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_random_traffic(input int count);
        kb_item_t    it;
        int          kind;
        int          burst;
        logic [31:0] raw;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            it = random_item();
            if (kind < 14)
            begin
                it.action = ACT_LOAD;
                if ($urandom_range(0, 9) < 7)
                    it.key_code = hot_keys[$urandom_range(0, HOT_KEYS-1)];
                send_item(it);
            end
            else if (kind < 42)
            begin
                burst = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 20) : 1;
                repeat (burst) send_key_event(pick_key(), $urandom_range(0, 1) == 1);
            end
            else if (kind < 45)
            begin
                it.action = ACT_UNUSED;
                send_item(it);
            end
            else
            begin
                raw = $urandom;
                send_read(raw[ADDR_W-1:0], pick_read_cycle());
            end
        end
    endtask

    task automatic test_directed_matrix();
        kb_item_t it;
        send_read(8'hFF, '0);
        it = random_item();
        it.action = ACT_UNUSED;
        send_item(it);
        send_load(8'h00, 3'd0, 3'd0, FORCE_NONE, MODE_BASE, 3'd7, 3'd7, FORCE_UP);
        send_load(8'hFF, 3'd7, 3'd0, FORCE_DOWN, MODE_SPARE, 3'd7, 3'd7, FORCE_SPARE);
        send_load(8'h41, 3'd1, 3'd7, FORCE_SPARE, MODE_ALT, 3'd6, 3'd3, FORCE_UP);
        send_load(8'h42, 3'd2, 3'd2, FORCE_UP, MODE_IGNORE, 3'd5, 3'd5, FORCE_DOWN);
        send_key_event(8'h00, 1'b1);
        send_read(8'h01, dequeue_mark + 1);
        // left shift down; a read exactly at the mark must not dequeue
        send_key_event(8'hFE, 1'b1);
        send_read(8'hFF, dequeue_mark);
        send_read(8'h00, dequeue_mark + 1);
        send_key_event(8'h41, 1'b1);
        send_read(8'hC2, dequeue_mark + 1);
        send_key_event(8'h42, 1'b1);
        send_read(8'h84, dequeue_mark + 1);
        send_key_event(8'hFE, 1'b0);
        send_read(8'hFF, dequeue_mark + 1);
        // release follows the shift state seen at press time
        send_key_event(8'h41, 1'b0);
        send_read(8'h42, dequeue_mark + 1);
        send_key_event(8'h77, 1'b1);
        send_read(8'hFF, dequeue_mark + 1);
        send_key_event(8'hFF, 1'b1);
        send_read(8'h80, dequeue_mark + 1);
    endtask

    task automatic test_config_sweep();
        logic [31:0] raw;
        for (int p = 0; p < 5; p++)
        begin
            wait_for_responses();
            raw = $urandom;
            case (p)
                0:
                begin
                    write_register(CFG_THROTTLE, '0);
                    write_register(CFG_LEFT_SHIFT, CFG_DATA_W'(8'h00));
                    write_register(CFG_RIGHT_SHIFT, CFG_DATA_W'(8'hFF));
                end
                1:
                begin
                    write_register(CFG_THROTTLE, '1);
                    write_register(CFG_LEFT_SHIFT, CFG_DATA_W'(8'hFF));
                    write_register(CFG_RIGHT_SHIFT, CFG_DATA_W'(8'h00));
                end
                2:
                begin
                    write_register(CFG_THROTTLE, CFG_DATA_W'(1));
                    write_register(CFG_LEFT_SHIFT, CFG_DATA_W'(raw[7:0]));
                    write_register(CFG_RIGHT_SHIFT, CFG_DATA_W'(raw[7:0]));
                end
                3:
                begin
                    write_register(CFG_THROTTLE, CFG_DATA_W'(THROTTLE_RST));
                    write_register(CFG_LEFT_SHIFT, CFG_DATA_W'(raw[7:0]));
                    write_register(CFG_RIGHT_SHIFT, CFG_DATA_W'(raw[15:8]));
                end
                default:
                begin
                    write_register(CFG_THROTTLE, CFG_DATA_W'($urandom_range(2, 5000)));
                    write_register(CFG_LEFT_SHIFT, CFG_DATA_W'(LEFT_SHIFT_RST));
                    write_register(CFG_RIGHT_SHIFT, CFG_DATA_W'(RIGHT_SHIFT_RST));
                end
            endcase
            refresh_hot_keys();
            run_random_traffic(PHASE_ITEMS);
        end
    endtask

    task automatic test_queue_overflow();
        logic [31:0] raw;
        repeat (QUEUE_DEPTH_DEF + 3) send_key_event(pick_key(), $urandom_range(0, 1) == 1);
        while (queued_key_events.size() != 0)
        begin
            raw = $urandom;
            send_read(raw[ADDR_W-1:0], dequeue_mark + 1);
        end
    endtask

    // runs last: once the mark saturates no further event can be dequeued
    task automatic test_cycle_saturation();
        wait_for_responses();
        write_register(CFG_THROTTLE, '1);
        send_key_event(pick_key(), 1'b1);
        send_key_event(pick_key(), 1'b0);
        send_read(8'hFF, CYCLE_MAX - 3);
        send_read(8'hFF, CYCLE_MAX);
        wait_for_responses();
        write_register(CFG_THROTTLE, '0);
        send_read(8'hFF, CYCLE_MAX);
        send_read(8'h80, CYCLE_MAX - 1);
    endtask

    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            result_bus.ready <= 1'b0;
        end
        else if ((rx_cycle / 300) % 3 != 0 && $urandom_range(0, 4) == 0)
        begin
            rx_stall_left = $urandom_range(0, 7);
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        kb_result_t due;
        kb_result_t seen;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            seen.read_data     = result_bus.read_data;
            seen.event_applied = result_bus.event_applied;
            seen.queue_dropped = result_bus.queue_dropped;
            if (responses_due.size() == 0)
                log_mismatch("unexpected transaction", '0, seen);
            else
            begin
                due = responses_due[0];
                responses_due.delete(0);
                if (seen.read_data !== due.read_data
                    || seen.event_applied !== due.event_applied
                    || seen.queue_dropped !== due.queue_dropped)
                    log_mismatch("result mismatch", due, seen);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, responses_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_THROTTLE;
        cfg_data         = '0;
        item_bus.valid   = 1'b0;
        item_bus.action  = ACT_LOAD;
        item_bus.key_code       = '0;
        item_bus.is_press       = 1'b0;
        item_bus.map_row        = '0;
        item_bus.map_column     = '0;
        item_bus.map_force      = FORCE_NONE;
        item_bus.shifted_mode   = MODE_BASE;
        item_bus.shifted_row    = '0;
        item_bus.shifted_column = '0;
        item_bus.shifted_force  = FORCE_NONE;
        item_bus.read_address   = '0;
        item_bus.now_cycle      = '0;

        throttle_setting = THROTTLE_RST;
        left_shift_key   = LEFT_SHIFT_RST;
        right_shift_key  = RIGHT_SHIFT_RST;
        for (int i = 0; i < ROWS; i++)
            matrix_rows[i] = '0;
        for (int k = 0; k < KEY_CODES_DEF; k++)
            key_map[k] = '0;
        row7_force       = FORCE_NONE;
        left_shift_down  = 1'b0;
        right_shift_down = 1'b0;
        dequeue_mark     = '0;
        refresh_hot_keys();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_matrix();
        test_config_sweep();
        test_queue_overflow();
        test_cycle_saturation();

        wait_for_responses();
        repeat (20) @(posedge clk);

        $display("Sent %0d transactions: %0d map loads, %0d key events (%0d dropped),",
                 loads_sent + events_sent + reads_sent + unused_sent, loads_sent,
                 events_sent, events_dropped);
        $display("%0d reads (%0d dequeued an event), %0d unused actions; %0d mismatches",
                 reads_sent, events_applied, unused_sent, mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
